@@ rtl/sbht_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbht_pkg: shared types and constants for the segment box hit test
// widths of the half-lsb geometry, lane records and output rounding
// ----------------------------------------------------------------------------
package sbht_pkg;

	// coordinate width, signed q16.16
	localparam int CW   = 32;
	// full box size width
	localparam int LW   = CW - 1;
	// point in half-lsb units
	localparam int HW   = CW + 1;
	// deltas and edges in half-lsb units
	localparam int DW   = CW + 2;
	// offsets relative to the segment start
	localparam int NW   = CW + 3;
	// magnitudes, divisor and quotient
	localparam int MW   = DW;
	localparam int QW   = MW;
	// split point of the wide multiplies
	localparam int SPL  = MW / 2;
	// full products
	localparam int PW   = 2 * MW;
	localparam int PARW = (MW - 1) + LW;
	// crossing coordinate before rounding
	localparam int PBW  = CW + 4;

	// epsilon register
	localparam int EPS_W = 33;
	localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(4294967);

	// registered stages in one lane: four front stages, the divide chain, the finish
	localparam int LANE_LAT = QW + 5;

	localparam logic signed [PBW:0] SAT_HI = signed'((PBW + 1)'({(CW - 1){1'b1}}));
	localparam logic signed [PBW:0] SAT_LO = -SAT_HI - (PBW + 1)'(1);

	typedef enum logic [1:0] {
		SIDE_TOP    = 2'd0,
		SIDE_BOTTOM = 2'd1,
		SIDE_LEFT   = 2'd2,
		SIDE_RIGHT  = 2'd3
	} side_t;

	// one candidate edge, a is the axis across the edge and b the axis along it
	typedef struct packed {
		logic signed [HW-1:0] sa;
		logic signed [HW-1:0] sb;
		logic signed [DW-1:0] da;
		logic signed [DW-1:0] db;
		logic signed [DW-1:0] c;
		logic signed [DW-1:0] lo;
		logic signed [DW-1:0] hi;
		logic [LW-1:0]        len;
		side_t                side;
	} lane_in_t;

	// what rides along the divide chain
	typedef struct packed {
		logic signed [HW-1:0] sb;
		logic                 db_neg;
		logic signed [NW-1:0] lrel;
		logic signed [NW-1:0] hrel;
		logic signed [NW-1:0] nlrel;
		logic signed [NW-1:0] nhrel;
		logic signed [DW-1:0] c;
		side_t                side;
		logic                 ok_pre;
	} div_ctx_t;

	typedef struct packed {
		logic                  ok;
		logic signed [PBW-1:0] pb;
		logic signed [DW-1:0]  c;
		side_t                 side;
	} lane_res_t;

	// half-lsb value to lsb, round half up, saturate
	function automatic logic [CW-1:0] round_sat(input logic signed [PBW-1:0] v);
		logic signed [PBW:0] t;
		logic signed [PBW:0] s;
		t = (PBW + 1)'(v) + (PBW + 1)'(1);
		s = t >>> 1;
		if (s > SAT_HI)
			return CW'(SAT_HI);
		else if (s < SAT_LO)
			return CW'(SAT_LO);
		else
			return CW'(s);
	endfunction

endpackage

@@ rtl/sbht_div_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbht_div_step: one restoring divide step
// one quotient bit per stage, context rides along
// ----------------------------------------------------------------------------
module sbht_div_step (
	input  logic                      clk,
	input  logic                      en,
	input  logic [sbht_pkg::MW-1:0]   d_i,
	input  logic [sbht_pkg::MW-1:0]   rem_i,
	input  logic [sbht_pkg::QW-1:0]   num_i,
	input  logic [sbht_pkg::QW-1:0]   q_i,
	input  sbht_pkg::div_ctx_t        ctx_i,
	output logic [sbht_pkg::MW-1:0]   d_o,
	output logic [sbht_pkg::MW-1:0]   rem_o,
	output logic [sbht_pkg::QW-1:0]   num_o,
	output logic [sbht_pkg::QW-1:0]   q_o,
	output sbht_pkg::div_ctx_t        ctx_o
);
	import sbht_pkg::*;

	logic [MW:0]   tmp;
	logic [MW:0]   diff;
	logic          ge;
	logic [MW-1:0] rem_n;

	logic [MW-1:0] d_s1;
	logic [MW-1:0] rem_s1;
	logic [QW-1:0] num_s1;
	logic [QW-1:0] q_s1;
	div_ctx_t      ctx_s1;

	always_comb begin
		tmp   = {rem_i, num_i[QW-1]};
		diff  = tmp - {1'b0, d_i};
		ge    = tmp >= {1'b0, d_i};
		rem_n = ge ? diff[MW-1:0] : tmp[MW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1   <= d_i;
			rem_s1 <= rem_n;
			num_s1 <= {num_i[QW-2:0], 1'b0};
			q_s1   <= {q_i[QW-2:0], ge};
			ctx_s1 <= ctx_i;
		end
	end

	assign d_o   = d_s1;
	assign rem_o = rem_s1;
	assign num_o = num_s1;
	assign q_o   = q_s1;
	assign ctx_o = ctx_s1;

endmodule

@@ rtl/sbht_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbht_lane: test of one candidate edge
// parallel check, span check, crossing by a pipelined divide, bounds check
// ----------------------------------------------------------------------------
module sbht_lane (
	input  logic                        clk,
	input  logic                        en,
	input  logic [sbht_pkg::EPS_W-1:0]  eps,
	input  sbht_pkg::lane_in_t          li,
	output sbht_pkg::lane_res_t         lr
);
	import sbht_pkg::*;

	// stage 2: magnitudes and offsets
	logic [MW-1:0]        mag_s2;
	logic [MW-1:0]        amag_s2;
	logic signed [NW-1:0] n_s2;
	logic                 dpos_s2;
	logic                 dnz_s2;
	logic                 dbneg_s2;
	logic signed [NW-1:0] lrel_s2;
	logic signed [NW-1:0] hrel_s2;
	logic signed [HW-1:0] sb_s2;
	logic signed [DW-1:0] c_s2;
	logic [LW-1:0]        len_s2;
	side_t                side_s2;

	// stage 3: distance to the edge, parallel partial products
	logic [MW-1:0]             e_s3;
	logic                      rok_s3;
	logic [SPL+LW-1:0]         pplo_s3;
	logic [MW-1-SPL+LW-1:0]    pphi_s3;
	logic [MW-1:0]             mag_s3;
	logic [MW-1:0]             amag_s3;
	div_ctx_t                  ctx_s3;

	// stage 4: parallel sum, crossing partial products
	logic [PARW-1:0]           par_s4;
	logic [SPL+MW-1:0]         eplo_s4;
	logic [MW-SPL+MW-1:0]      ephi_s4;
	logic                      rok_s4;
	logic [MW-1:0]             mag_s4;
	div_ctx_t                  ctx_s4;

	// stage 5: divide operands
	logic [PW-1:0]             prod_s5;
	logic                      parl_s5;
	logic                      rok_s5;
	logic [MW-1:0]             mag_s5;
	div_ctx_t                  ctx_s5;

	logic signed [NW-1:0] e_n;
	div_ctx_t             ctx5_n;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2   <= li.da[DW-1] ? MW'(-li.da) : MW'(li.da);
			amag_s2  <= li.db[DW-1] ? MW'(-li.db) : MW'(li.db);
			n_s2     <= NW'(li.c) - NW'(li.sa);
			dpos_s2  <= !li.da[DW-1] && (li.da != '0);
			dnz_s2   <= li.da != '0;
			dbneg_s2 <= li.db[DW-1];
			lrel_s2  <= NW'(li.lo) - NW'(li.sb);
			hrel_s2  <= NW'(li.hi) - NW'(li.sb);
			sb_s2    <= li.sb;
			c_s2     <= li.c;
			len_s2   <= li.len;
			side_s2  <= li.side;
		end
	end

	assign e_n = dpos_s2 ? n_s2 : -n_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			e_s3          <= e_n[MW-1:0];
			rok_s3        <= dnz_s2 && !e_n[NW-1] && (e_n <= signed'(NW'(mag_s2)));
			pplo_s3       <= mag_s2[SPL:1] * len_s2;
			pphi_s3       <= mag_s2[MW-1:SPL+1] * len_s2;
			mag_s3        <= mag_s2;
			amag_s3       <= amag_s2;
			ctx_s3.sb     <= sb_s2;
			ctx_s3.db_neg <= dbneg_s2;
			ctx_s3.lrel   <= lrel_s2;
			ctx_s3.hrel   <= hrel_s2;
			ctx_s3.nlrel  <= -lrel_s2;
			ctx_s3.nhrel  <= -hrel_s2;
			ctx_s3.c      <= c_s2;
			ctx_s3.side   <= side_s2;
			ctx_s3.ok_pre <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			par_s4  <= PARW'(pplo_s3) + (PARW'(pphi_s3) << SPL);
			eplo_s4 <= e_s3[SPL-1:0] * amag_s3;
			ephi_s4 <= e_s3[MW-1:SPL] * amag_s3;
			rok_s4  <= rok_s3;
			mag_s4  <= mag_s3;
			ctx_s4  <= ctx_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5 <= PW'(eplo_s4) + (PW'(ephi_s4) << SPL);
			parl_s5 <= par_s4 <= PARW'(eps);
			rok_s5  <= rok_s4;
			mag_s5  <= mag_s4;
			ctx_s5  <= ctx_s4;
		end
	end

	always_comb begin
		ctx5_n        = ctx_s5;
		ctx5_n.ok_pre = rok_s5 && !parl_s5;
	end

	// divide chain, one quotient bit per stage
	logic [MW-1:0] dv_d   [QW+1];
	logic [MW-1:0] dv_rem [QW+1];
	logic [QW-1:0] dv_num [QW+1];
	logic [QW-1:0] dv_q   [QW+1];
	div_ctx_t      dv_ctx [QW+1];

	assign dv_d[0]   = mag_s5;
	assign dv_rem[0] = prod_s5[PW-1:QW];
	assign dv_num[0] = prod_s5[QW-1:0];
	assign dv_q[0]   = '0;
	assign dv_ctx[0] = ctx5_n;

	for (genvar g = 0; g < QW; g++) begin : g_div
		sbht_div_step u_step (
			.clk   (clk),
			.en    (en),
			.d_i   (dv_d[g]),
			.rem_i (dv_rem[g]),
			.num_i (dv_num[g]),
			.q_i   (dv_q[g]),
			.ctx_i (dv_ctx[g]),
			.d_o   (dv_d[g+1]),
			.rem_o (dv_rem[g+1]),
			.num_o (dv_num[g+1]),
			.q_o   (dv_q[g+1]),
			.ctx_o (dv_ctx[g+1])
		);
	end

	// finish: bounds along the edge and the crossing coordinate
	div_ctx_t              fc;
	logic signed [NW-1:0]  qs;
	logic                  r0;
	logic                  okg;
	logic signed [PBW-1:0] pb_n;
	lane_res_t             res_s6;

	always_comb begin
		fc = dv_ctx[QW];
		qs = signed'(NW'(dv_q[QW]));
		r0 = dv_rem[QW] == '0;
		if (fc.db_neg) begin
			okg  = ((qs < fc.nlrel) || (qs == fc.nlrel && r0)) && (qs >= fc.nhrel);
			pb_n = PBW'(fc.sb) - signed'(PBW'(dv_q[QW])) - signed'(PBW'(!r0));
		end else begin
			okg  = (qs >= fc.lrel) && ((qs < fc.hrel) || (qs == fc.hrel && r0));
			pb_n = PBW'(fc.sb) + signed'(PBW'(dv_q[QW]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s6.ok   <= okg && fc.ok_pre;
			res_s6.pb   <= pb_n;
			res_s6.c    <= fc.c;
			res_s6.side <= fc.side;
		end
	end

	assign lr = res_s6;

endmodule

@@ rtl/sbht_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbht_out: edge priority, rounding and the output buffer
// an output register with one skid entry behind it
// ----------------------------------------------------------------------------
module sbht_out (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pipe_valid,
	input  sbht_pkg::lane_res_t        hres,
	input  sbht_pkg::lane_res_t        vres,
	output logic                       adv,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       hit,
	output logic [1:0]                 side,
	output logic [sbht_pkg::CW-1:0]    hit_x,
	output logic [sbht_pkg::CW-1:0]    hit_y
);
	import sbht_pkg::*;

	logic          n_hit;
	side_t         n_side;
	logic [CW-1:0] n_x;
	logic [CW-1:0] n_y;

	logic          out_valid_q;
	logic          hit_q;
	side_t         side_q;
	logic [CW-1:0] x_q;
	logic [CW-1:0] y_q;

	logic          skid_valid_q;
	logic          skid_hit_q;
	side_t         skid_side_q;
	logic [CW-1:0] skid_x_q;
	logic [CW-1:0] skid_y_q;

	logic take;

	// horizontal edge wins over vertical one
	always_comb begin
		n_hit  = 1'b0;
		n_side = SIDE_TOP;
		n_x    = '0;
		n_y    = '0;
		if (hres.ok) begin
			n_hit  = 1'b1;
			n_side = hres.side;
			n_x    = round_sat(hres.pb);
			n_y    = round_sat(PBW'(hres.c));
		end else if (vres.ok) begin
			n_hit  = 1'b1;
			n_side = vres.side;
			n_x    = round_sat(PBW'(vres.c));
			n_y    = round_sat(vres.pb);
		end
	end

	assign take = out_valid_q && out_ready;
	assign adv  = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (take)
					skid_valid_q <= 1'b0;
			end else if (pipe_valid) begin
				if (out_valid_q && !take)
					skid_valid_q <= 1'b1;
				else
					out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				hit_q  <= skid_hit_q;
				side_q <= skid_side_q;
				x_q    <= skid_x_q;
				y_q    <= skid_y_q;
			end
		end else if (pipe_valid) begin
			if (out_valid_q && !take) begin
				skid_hit_q  <= n_hit;
				skid_side_q <= n_side;
				skid_x_q    <= n_x;
				skid_y_q    <= n_y;
			end else begin
				hit_q  <= n_hit;
				side_q <= n_side;
				x_q    <= n_x;
				y_q    <= n_y;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign side      = side_q;
	assign hit_x     = x_q;
	assign hit_y     = y_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with empty output register");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !hit_q) |-> (side_q == SIDE_TOP && x_q == '0 && y_q == '0))
		else $error("miss result carries a side or position");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !out_ready) |=> (skid_valid_q && $stable(skid_x_q)))
		else $error("skid entry lost while output stalled");

endmodule

@@ rtl/segment_box_hit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_box_hit_test: motion segment against an axis-aligned box
// first edge in the order top, bottom, left, right crossed against its normal
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  request   in_valid / in_ready    start_x/y, end_x/y, box_center_x/y,
//                                   box_width, box_height
//  result    out_valid / out_ready  hit, side, hit_x, hit_y
//  config    cfg_wr_en              cfg_wr_data (parallel epsilon)
//
//  one request per cycle while in_ready is high; a request passes 41 registers
//  (input stage, four lane stages, 34 divide steps, finish, output register;
//  the input stage loads at the accepting edge)
//  the divide chain, one quotient bit per stage, sets the depth
//  arst_n clears the valid bits, also those of the output buffer, and sets epsilon to reset
//  a stall of out_ready fills a one-entry skid; in_ready drops only then
//  and the whole pipeline freezes, nothing is dropped or repeated
// ----------------------------------------------------------------------------
module segment_box_hit_test (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [sbht_pkg::EPS_W-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [sbht_pkg::CW-1:0] start_x,
	input  logic signed [sbht_pkg::CW-1:0] start_y,
	input  logic signed [sbht_pkg::CW-1:0] end_x,
	input  logic signed [sbht_pkg::CW-1:0] end_y,
	input  logic signed [sbht_pkg::CW-1:0] box_center_x,
	input  logic signed [sbht_pkg::CW-1:0] box_center_y,
	input  logic [sbht_pkg::LW-1:0]     box_width,
	input  logic [sbht_pkg::LW-1:0]     box_height,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        hit,
	output logic [1:0]                  side,
	output logic signed [sbht_pkg::CW-1:0] hit_x,
	output logic signed [sbht_pkg::CW-1:0] hit_y
);
	import sbht_pkg::*;

	logic [EPS_W-1:0] eps_q;
	logic             adv;

	// everything in half-lsb units so that half sizes stay exact
	logic signed [HW-1:0] sx2, sy2, ex2, ey2, cx2, cy2;
	logic signed [DW-1:0] dx, dy;
	logic signed [DW-1:0] e_top, e_bot, e_lft, e_rgt;
	logic signed [DW-1:0] wd, hd;
	lane_in_t             h_n, v_n;

	lane_in_t             h_s1, v_s1;
	logic                 vld_s1;
	logic                 vld_pipe_q [LANE_LAT];

	lane_res_t            hres, vres;
	logic [CW-1:0]        ux, uy;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			eps_q <= EPS_RESET;
		else if (cfg_wr_en)
			eps_q <= cfg_wr_data;
	end

	always_comb begin
		sx2   = {start_x, 1'b0};
		sy2   = {start_y, 1'b0};
		ex2   = {end_x, 1'b0};
		ey2   = {end_y, 1'b0};
		cx2   = {box_center_x, 1'b0};
		cy2   = {box_center_y, 1'b0};
		wd    = signed'(DW'(box_width));
		hd    = signed'(DW'(box_height));
		dx    = DW'(ex2) - DW'(sx2);
		dy    = DW'(ey2) - DW'(sy2);
		e_top = DW'(cy2) + hd;
		e_bot = DW'(cy2) - hd;
		e_lft = DW'(cx2) - wd;
		e_rgt = DW'(cx2) + wd;

		// only the edge facing the motion can count: top when moving down
		h_n.sa   = sy2;
		h_n.sb   = sx2;
		h_n.da   = dy;
		h_n.db   = dx;
		h_n.c    = dy[DW-1] ? e_top : e_bot;
		h_n.lo   = e_lft;
		h_n.hi   = e_rgt;
		h_n.len  = box_width;
		h_n.side = dy[DW-1] ? SIDE_TOP : SIDE_BOTTOM;

		// left when moving right, right otherwise
		v_n.sa   = sx2;
		v_n.sb   = sy2;
		v_n.da   = dx;
		v_n.db   = dy;
		v_n.c    = (!dx[DW-1] && dx != '0) ? e_lft : e_rgt;
		v_n.lo   = e_bot;
		v_n.hi   = e_top;
		v_n.len  = box_height;
		v_n.side = (!dx[DW-1] && dx != '0) ? SIDE_LEFT : SIDE_RIGHT;
	end

	// input stage
	always_ff @(posedge clk) begin
		if (adv) begin
			h_s1 <= h_n;
			v_s1 <= v_n;
		end
	end

	// valid bits ride beside the lane stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int i = 0; i < LANE_LAT; i++)
				vld_pipe_q[i] <= 1'b0;
		end else if (adv) begin
			vld_s1        <= in_valid;
			vld_pipe_q[0] <= vld_s1;
			for (int i = 1; i < LANE_LAT; i++)
				vld_pipe_q[i] <= vld_pipe_q[i-1];
		end
	end

	assign in_ready = adv;

	sbht_lane u_lane_h (
		.clk (clk),
		.en  (adv),
		.eps (eps_q),
		.li  (h_s1),
		.lr  (hres)
	);

	sbht_lane u_lane_v (
		.clk (clk),
		.en  (adv),
		.eps (eps_q),
		.li  (v_s1),
		.lr  (vres)
	);

	sbht_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.pipe_valid (vld_pipe_q[LANE_LAT-1]),
		.hres       (hres),
		.vres       (vres),
		.adv        (adv),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.side       (side),
		.hit_x      (ux),
		.hit_y      (uy)
	);

	assign hit_x = signed'(ux);
	assign hit_y = signed'(uy);

endmodule
